>>> sv/bbl_pkg.sv
`default_nettype none
package bbl_pkg;

  // Table geometry.
  localparam int ENTRIES  = 64;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int KEY_BITS = 64;
  localparam int KEY_W    = 64;
  localparam int SIZE_W   = 17;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_BITS) - KEY_W'(1));

  localparam logic [31:0] CAP_RESET = 32'd1048576;

  // Request kinds.
  localparam logic [1:0] ACT_GET   = 2'd0;
  localparam logic [1:0] ACT_PUT   = 2'd1;
  localparam logic [1:0] ACT_INVAL = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // Operation broadcast to every cell.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_FRONT,
    OP_DROP,
    OP_INSERT,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   rank;
    logic [KEY_W-1:0]   key;
    logic [7:0]         klen;
    logic [15:0]        dlen;
  } cell_cmd_t;

  // Results gathered along the chain of cells.
  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_rank;
    logic [IDX_W-1:0]   hit_slot;
    logic [15:0]        hit_dlen;
    logic [SIZE_W-1:0]  hit_size;
    logic               old_hit;
    logic [SIZE_W-1:0]  old_size;
    logic               free_found;
    logic [IDX_W-1:0]   free_slot;
  } chain_t;

endpackage
`default_nettype wire

>>> sv/bbl_if.sv
`default_nettype none
interface bbl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] key;
  logic [7:0]  key_length;
  logic [15:0] data_length;
  modport source (output valid, action, key, key_length, data_length, input ready);
  modport sink   (input valid, action, key, key_length, data_length, output ready);
endinterface

interface bbl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [5:0]  slot;
  logic [15:0] length_out;
  logic        stored;
  logic [6:0]  evicted;
  logic [31:0] bytes_used;
  logic [6:0]  entry_count;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  modport source (output valid, found, slot, length_out, stored, evicted, bytes_used,
                  entry_count, hit_total, miss_total, input ready);
  modport sink   (input valid, found, slot, length_out, stored, evicted, bytes_used,
                  entry_count, hit_total, miss_total, output ready);
endinterface

interface bbl_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> sv/bbl_cell.sv
`default_nettype none
module bbl_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire [bbl_pkg::IDX_W-1:0]   cell_idx,
  input  wire bbl_pkg::cell_cmd_t    cmd,
  input  wire bbl_pkg::chain_t       acc_in,
  output bbl_pkg::chain_t            acc_out
);

  logic                          valid_r;
  logic [bbl_pkg::KEY_W-1:0]     key_r;
  logic [7:0]                    klen_r;
  logic [15:0]                   dlen_r;
  logic [bbl_pkg::IDX_W-1:0]     rank_r;
  logic                          match;
  logic                          at_rank;
  logic                          take;
  logic [bbl_pkg::SIZE_W-1:0]    size;

  assign match   = valid_r && (key_r == cmd.key) && (klen_r == cmd.klen);
  assign at_rank = valid_r && (rank_r == cmd.rank);
  assign take    = !valid_r && !acc_in.free_found;
  assign size    = bbl_pkg::SIZE_W'(klen_r) + bbl_pkg::SIZE_W'(dlen_r);

  // Merge this slot's contribution into the running chain result.
  always_comb begin
    acc_out = acc_in;
    if (match) begin
      acc_out.hit      = 1'b1;
      acc_out.hit_rank = rank_r;
      acc_out.hit_slot = cell_idx;
      acc_out.hit_dlen = dlen_r;
      acc_out.hit_size = size;
    end
    if (at_rank) begin
      acc_out.old_hit  = 1'b1;
      acc_out.old_size = size;
    end
    if (take) begin
      acc_out.free_found = 1'b1;
      acc_out.free_slot  = cell_idx;
    end
  end

  // Valid flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        bbl_pkg::OP_DROP:   if (at_rank) valid_r <= 1'b0;
        bbl_pkg::OP_INSERT: if (take) valid_r <= 1'b1;
        bbl_pkg::OP_CLEAR:  valid_r <= 1'b0;
        default:            valid_r <= valid_r;
      endcase
    end
  end

  // Entry payload and recency rank.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bbl_pkg::OP_FRONT: begin
        if (at_rank) rank_r <= '0;
        else if (valid_r && rank_r < cmd.rank) rank_r <= rank_r + 1'b1;
      end
      bbl_pkg::OP_DROP: begin
        if (valid_r && rank_r > cmd.rank) rank_r <= rank_r - 1'b1;
      end
      bbl_pkg::OP_INSERT: begin
        if (take) begin
          key_r  <= cmd.key;
          klen_r <= cmd.klen;
          dlen_r <= cmd.dlen;
          rank_r <= '0;
        end else if (valid_r) begin
          rank_r <= rank_r + 1'b1;
        end
      end
      default: rank_r <= rank_r;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/byte_budget_lru_directory.sv
// Byte-budget LRU directory: a 64-slot table of keys with data lengths and
// recency order, a running byte usage and saturating hit and miss counters.
// Channels: in_ch carries one request (get, put, invalidate, clear); out_ch
// returns one result per request; cfg_ch writes byte_capacity and is always
// ready, and should be written only while no request is in flight.
// Steps: get, invalidate, clear and a put that is too large pass through look,
// exec and done before the output register; a stored put passes through look,
// exec, one evict step per evicted entry (up to 64) plus a final one, insert
// and done. Only one request is processed at a time; in_ch becomes ready in the
// same cycle as the output valid rises. The eviction walk, one entry per cycle,
// sets the worst case.
// Every slot is a cell in a chain; match, oldest-entry and free-slot results
// ripple through the chain, and each cell updates its own rank.
// Reset (rst_n low at a clock edge) empties the table, zeroes usage and
// counters and sets byte_capacity to 1048576.
// When the receiver stalls the result waits in the output register; the next
// request is still accepted and its result waits in the done state.
`default_nettype none
module byte_budget_lru_directory (
  input  wire         clk,
  input  wire         rst_n,
  bbl_in_if.sink      in_ch,
  bbl_out_if.source   out_ch,
  bbl_cfg_if.sink     cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_EVICT,
    S_INS,
    S_DONE
  } state_t;

  state_t                              state_r;
  logic [1:0]                          act_r;
  logic [bbl_pkg::KEY_W-1:0]           key_r;
  logic [7:0]                          klen_r;
  logic [15:0]                         dlen_r;
  logic [31:0]                         cap_r;
  logic [31:0]                         usage_r;
  logic [bbl_pkg::CNT_W-1:0]           count_r;
  logic [31:0]                         hit_r;
  logic [31:0]                         miss_r;
  logic                                m_hit_r;
  logic [bbl_pkg::IDX_W-1:0]           m_rank_r;
  logic [bbl_pkg::IDX_W-1:0]           m_slot_r;
  logic [15:0]                         m_dlen_r;
  logic [bbl_pkg::SIZE_W-1:0]          m_size_r;
  logic                                res_found_r;
  logic [bbl_pkg::IDX_W-1:0]           res_slot_r;
  logic [15:0]                         res_len_r;
  logic                                res_stored_r;
  logic [6:0]                          evict_r;
  logic                                out_valid_r;

  bbl_pkg::cell_cmd_t                  cmd;
  bbl_pkg::chain_t                     chain [bbl_pkg::ENTRIES+1];
  logic [bbl_pkg::SIZE_W-1:0]          req_size;
  logic [bbl_pkg::CNT_W-1:0]           rank_dec;
  logic                                need_drop;
  logic                                in_xfer;
  logic                                out_load;

  assign req_size  = bbl_pkg::SIZE_W'(klen_r) + bbl_pkg::SIZE_W'(dlen_r);
  assign rank_dec  = count_r - 1'b1;
  assign need_drop = ((count_r != '0) &&
                      ({1'b0, usage_r} + 33'(req_size) > {1'b0, cap_r})) ||
                     (count_r == bbl_pkg::CNT_W'(bbl_pkg::ENTRIES));
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid = out_valid_r;

  // Command broadcast to the cells for the current step.
  always_comb begin
    cmd.op   = bbl_pkg::OP_NOP;
    cmd.rank = m_rank_r;
    cmd.key  = key_r;
    cmd.klen = klen_r;
    cmd.dlen = dlen_r;
    unique case (state_r)
      S_EXEC: begin
        unique case (act_r)
          bbl_pkg::ACT_GET:   if (m_hit_r) cmd.op = bbl_pkg::OP_FRONT;
          bbl_pkg::ACT_PUT:   if (m_hit_r) cmd.op = bbl_pkg::OP_DROP;
          bbl_pkg::ACT_INVAL: if (m_hit_r) cmd.op = bbl_pkg::OP_DROP;
          default:            cmd.op = bbl_pkg::OP_CLEAR;
        endcase
      end
      S_EVICT: begin
        cmd.rank = rank_dec[bbl_pkg::IDX_W-1:0];
        if (need_drop) cmd.op = bbl_pkg::OP_DROP;
      end
      S_INS:   cmd.op = bbl_pkg::OP_INSERT;
      default: cmd.op = bbl_pkg::OP_NOP;
    endcase
  end

  // Chain of slot cells.
  assign chain[0] = '0;
  for (genvar i = 0; i < bbl_pkg::ENTRIES; i++) begin : g_cell
    bbl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (bbl_pkg::IDX_W'(i)),
      .cmd      (cmd),
      .acc_in   (chain[i]),
      .acc_out  (chain[i+1])
    );
  end

  // Sequencer, table totals and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= bbl_pkg::CAP_RESET;
      usage_r     <= '0;
      count_r     <= '0;
      hit_r       <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) cap_r <= cfg_ch.data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            act_r        <= in_ch.action;
            key_r        <= in_ch.key & bbl_pkg::KEY_MASK;
            klen_r       <= in_ch.key_length;
            dlen_r       <= in_ch.data_length;
            res_found_r  <= 1'b0;
            res_slot_r   <= '0;
            res_len_r    <= '0;
            res_stored_r <= 1'b0;
            evict_r      <= '0;
            state_r      <= S_LOOK;
          end
        end
        S_LOOK: begin
          m_hit_r  <= chain[bbl_pkg::ENTRIES].hit;
          m_rank_r <= chain[bbl_pkg::ENTRIES].hit_rank;
          m_slot_r <= chain[bbl_pkg::ENTRIES].hit_slot;
          m_dlen_r <= chain[bbl_pkg::ENTRIES].hit_dlen;
          m_size_r <= chain[bbl_pkg::ENTRIES].hit_size;
          state_r  <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_DONE;
          unique case (act_r)
            bbl_pkg::ACT_GET: begin
              if (m_hit_r) begin
                if (hit_r != '1) hit_r <= hit_r + 1'b1;
                res_found_r <= 1'b1;
                res_slot_r  <= m_slot_r;
                res_len_r   <= m_dlen_r;
              end else if (miss_r != '1) begin
                miss_r <= miss_r + 1'b1;
              end
            end
            bbl_pkg::ACT_PUT: begin
              if (m_hit_r) begin
                usage_r <= usage_r - 32'(m_size_r);
                count_r <= count_r - 1'b1;
              end
              if (32'(req_size) <= cap_r) state_r <= S_EVICT;
            end
            bbl_pkg::ACT_INVAL: begin
              if (m_hit_r) begin
                usage_r     <= usage_r - 32'(m_size_r);
                count_r     <= count_r - 1'b1;
                res_found_r <= 1'b1;
                res_slot_r  <= m_slot_r;
              end
            end
            default: begin
              usage_r <= '0;
              count_r <= '0;
            end
          endcase
        end
        S_EVICT: begin
          if (need_drop) begin
            usage_r <= usage_r - 32'(chain[bbl_pkg::ENTRIES].old_size);
            count_r <= count_r - 1'b1;
            if (evict_r != '1) evict_r <= evict_r + 1'b1;
          end else begin
            state_r <= S_INS;
          end
        end
        S_INS: begin
          usage_r      <= usage_r + 32'(req_size);
          count_r      <= count_r + 1'b1;
          res_stored_r <= 1'b1;
          res_slot_r   <= chain[bbl_pkg::ENTRIES].free_slot;
          state_r      <= S_DONE;
        end
        default: begin
          if (out_load) state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.found       <= res_found_r;
      out_ch.slot        <= 6'(res_slot_r);
      out_ch.length_out  <= res_len_r;
      out_ch.stored      <= res_stored_r;
      out_ch.evicted     <= evict_r;
      out_ch.bytes_used  <= usage_r;
      out_ch.entry_count <= 7'(count_r);
      out_ch.hit_total   <= hit_r;
      out_ch.miss_total  <= miss_r;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bbl_pkg::CNT_W'(bbl_pkg::ENTRIES))
    else $error("entry count above table size");

  a_free_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |-> chain[bbl_pkg::ENTRIES].free_found)
    else $error("insert without a free slot");

  a_oldest_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT && need_drop) |-> chain[bbl_pkg::ENTRIES].old_hit)
    else $error("eviction found no least recent entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && act_r == bbl_pkg::ACT_CLEAR) |=>
      (usage_r == '0 && count_r == '0))
    else $error("clear left entries behind");
`endif

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    bit        found;
    bit [5:0]  slot;
    bit [15:0] length_out;
    bit        stored;
    bit [6:0]  evicted;
    bit [31:0] bytes_used;
    bit [6:0]  entry_count;
    bit [31:0] hit_total;
    bit [31:0] miss_total;
  } dir_result_t;

  // Directory scoreboard: mirrors the table and holds results still owed.
  class dir_scoreboard;
    bit        live[bbl_pkg::ENTRIES];
    bit [63:0] tag[bbl_pkg::ENTRIES];
    bit [7:0]  tag_len[bbl_pkg::ENTRIES];
    bit [15:0] payload_len[bbl_pkg::ENTRIES];
    int        age[bbl_pkg::ENTRIES];
    bit [31:0] capacity;
    bit [31:0] usage;
    bit [31:0] hits;
    bit [31:0] misses;
    int        population;
    int        errors;
    dir_result_t owed[$];

    function new();
      capacity = bbl_pkg::CAP_RESET;
      usage = 0;
      hits = 0;
      misses = 0;
      population = 0;
      errors = 0;
      foreach (live[i]) begin
        live[i] = 0;
        age[i] = 0;
      end
    endfunction

    function int lookup(bit [63:0] k, bit [7:0] kl);
      for (int i = 0; i < bbl_pkg::ENTRIES; i++)
        if (live[i] && tag[i] == k && tag_len[i] == kl) return i;
      return -1;
    endfunction

    function void remove(int s);
      for (int i = 0; i < bbl_pkg::ENTRIES; i++)
        if (live[i] && age[i] > age[s]) age[i]--;
      live[s] = 0;
      usage -= tag_len[s] + payload_len[s];
      population--;
    endfunction

    function void remove_oldest();
      for (int i = 0; i < bbl_pkg::ENTRIES; i++)
        if (live[i] && age[i] + 1 == population) begin
          remove(i);
          return;
        end
    endfunction

    // Note an accepted request and queue the result it must produce.
    function void note_request(bit [1:0] act, bit [63:0] k, bit [7:0] kl, bit [15:0] dl);
      dir_result_t r;
      int s;
      int dropped;
      longint size;
      r = '{default: 0};
      k &= bbl_pkg::KEY_MASK;
      dropped = 0;
      case (act)
        bbl_pkg::ACT_GET: begin
          s = lookup(k, kl);
          if (s >= 0) begin
            for (int i = 0; i < bbl_pkg::ENTRIES; i++)
              if (live[i] && age[i] < age[s]) age[i]++;
            age[s] = 0;
            if (hits != 32'hFFFF_FFFF) hits++;
            r.found = 1;
            r.slot = s;
            r.length_out = payload_len[s];
          end else if (misses != 32'hFFFF_FFFF) misses++;
        end
        bbl_pkg::ACT_PUT: begin
          size = kl + dl;
          s = lookup(k, kl);
          if (s >= 0) remove(s);
          if (size <= capacity) begin
            while (population > 0 && longint'(usage) + size > capacity) begin
              remove_oldest();
              dropped++;
            end
            if (population >= bbl_pkg::ENTRIES) begin
              remove_oldest();
              dropped++;
            end
            for (s = 0; s < bbl_pkg::ENTRIES && live[s]; s++) ;
            if (s < bbl_pkg::ENTRIES) begin
              for (int i = 0; i < bbl_pkg::ENTRIES; i++) if (live[i]) age[i]++;
              live[s] = 1;
              tag[s] = k;
              tag_len[s] = kl;
              payload_len[s] = dl;
              age[s] = 0;
              usage += size;
              population++;
              r.stored = 1;
              r.slot = s;
            end
          end
          r.evicted = (dropped > 127) ? 127 : dropped;
        end
        bbl_pkg::ACT_INVAL: begin
          s = lookup(k, kl);
          if (s >= 0) begin
            remove(s);
            r.found = 1;
            r.slot = s;
          end
        end
        default: begin
          foreach (live[i]) live[i] = 0;
          usage = 0;
          population = 0;
        end
      endcase
      r.bytes_used = usage;
      r.entry_count = population;
      r.hit_total = hits;
      r.miss_total = misses;
      owed.push_back(r);
    endfunction

    function void check_field(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest owed result.
    function void check_result(dir_result_t got);
      dir_result_t e;
      if (owed.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      e = owed.pop_front();
      check_field("found", e.found, got.found);
      check_field("slot", e.slot, got.slot);
      check_field("length_out", e.length_out, got.length_out);
      check_field("stored", e.stored, got.stored);
      check_field("evicted", e.evicted, got.evicted);
      check_field("bytes_used", e.bytes_used, got.bytes_used);
      check_field("entry_count", e.entry_count, got.entry_count);
      check_field("hit_total", e.hit_total, got.hit_total);
      check_field("miss_total", e.miss_total, got.miss_total);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  bbl_in_if  in_ch();
  bbl_out_if out_ch();
  bbl_cfg_if cfg_ch();

  byte_budget_lru_directory u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  dir_scoreboard board = new();
  bit  calm_phase = 0;
  int  hold_off = 0;
  bit  [63:0] key_pool[8];
  bit  [7:0]  klen_pool[8];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.action = bbl_pkg::ACT_GET;
    in_ch.key = 0;
    in_ch.key_length = 0;
    in_ch.data_length = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result('{out_ch.found, out_ch.slot, out_ch.length_out, out_ch.stored,
                           out_ch.evicted, out_ch.bytes_used, out_ch.entry_count,
                           out_ch.hit_total, out_ch.miss_total});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= calm_phase || ($urandom_range(99) >= 14);
    end
  end

  // Send one request, with a random gap before it. The block is busy after a
  // transfer, so the first edge costs no throughput.
  task automatic send_request(bit [1:0] act, bit [63:0] k, bit [7:0] kl, bit [15:0] dl);
    @(posedge clk);
    while (!calm_phase && $urandom_range(99) < 14) @(posedge clk);
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.key <= k;
    in_ch.key_length <= kl;
    in_ch.data_length <= dl;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(act, k, kl, dl);
    in_ch.valid <= 0;
  endtask

  task automatic drain();
    while (board.owed.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_capacity(bit [31:0] value);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    board.capacity = value;
  endtask

  // One random request; most reuse a small key pool so gets and puts hit.
  task automatic random_request(int big_chance);
    int p;
    bit [1:0] act;
    bit [15:0] dl;
    p = $urandom_range(7);
    case ($urandom_range(9))
      0, 1, 2: act = bbl_pkg::ACT_GET;
      3, 4, 5, 6: act = bbl_pkg::ACT_PUT;
      7, 8: act = bbl_pkg::ACT_INVAL;
      default: act = ($urandom_range(9) == 0) ? bbl_pkg::ACT_CLEAR : bbl_pkg::ACT_PUT;
    endcase
    dl = ($urandom_range(99) < big_chance) ? 16'($urandom) : 16'($urandom_range(300));
    if ($urandom_range(9) < 8)
      send_request(act, key_pool[p], klen_pool[p], dl);
    else
      send_request(act, {$urandom, $urandom}, 8'($urandom), dl);
  endtask

  initial begin
    int n;
    bit [31:0] caps[5];
    caps = '{32'd0, 32'd1, 32'd600, 32'd5000, 32'hFFFF_FFFF};
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      klen_pool[i] = 8'($urandom_range(8));
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, every request kind, re-put, oversize, full table.
    send_request(bbl_pkg::ACT_GET, 64'h0, 8'h0, 16'h0);
    send_request(bbl_pkg::ACT_PUT, 64'h0, 8'h0, 16'h0);
    send_request(bbl_pkg::ACT_GET, 64'h0, 8'h0, 16'hFFFF);
    send_request(bbl_pkg::ACT_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'hFFFF);
    send_request(bbl_pkg::ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'h0);
    send_request(bbl_pkg::ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFE, 16'h0);
    send_request(bbl_pkg::ACT_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'h10);
    send_request(bbl_pkg::ACT_INVAL, 64'h0, 8'h0, 16'h0);
    send_request(bbl_pkg::ACT_INVAL, 64'h0, 8'h0, 16'h0);
    send_request(bbl_pkg::ACT_CLEAR, 64'h0, 8'h0, 16'h0);
    send_request(bbl_pkg::ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'h0);
    write_capacity(32'd100);
    send_request(bbl_pkg::ACT_PUT, 64'h1234, 8'd8, 16'd93);
    send_request(bbl_pkg::ACT_PUT, 64'h1235, 8'd8, 16'd40);
    send_request(bbl_pkg::ACT_PUT, 64'h1236, 8'd8, 16'd40);
    send_request(bbl_pkg::ACT_PUT, 64'h1237, 8'd8, 16'd200);
    // Fill the table past its slot count so the full-table rule evicts.
    write_capacity(32'hFFFF_FFFF);
    for (int i = 0; i < 70; i++) send_request(bbl_pkg::ACT_PUT, 64'(i), 8'd1, 16'd1);
    // Lowered capacity: the next put evicts down to it.
    write_capacity(32'd20);
    send_request(bbl_pkg::ACT_PUT, 64'h99, 8'd2, 16'd2);

    // Random phases over several capacities, including the extremes.
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(ph < 5 ? caps[ph] : $urandom_range(20000, 200));
      calm_phase = (ph == 3);
      if (ph == 2) hold_off = 300;
      n = 200;
      for (int i = 0; i < n; i++) random_request(ph == 4 ? 50 : 5);
    end

    drain();
    if (board.errors == 0 && board.owed.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
